### rtl/core/button_long_press_detector_macros.svh
// assertion helpers for the button press detector
`ifndef BUTTON_LONG_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_LONG_PRESS_DETECTOR_MACROS_SVH

// condition and consequence in the same cycle
`define BLPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/blpd_pkg.sv
`default_nettype none

package blpd_pkg;

    // field and register widths
    localparam int NUM_PIN_REGS = 4;
    localparam int PIN_W        = 8;
    localparam int TIME_W       = 32;
    localparam int TOUT_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int BTN_IDX_W    = 2;

    // request kinds
    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // result actions
    localparam logic [1:0] ACT_PRESS        = 2'd0;
    localparam logic [1:0] ACT_RELEASE      = 2'd1;
    localparam logic [1:0] ACT_LONG         = 2'd2;
    localparam logic [1:0] ACT_LONG_RELEASE = 2'd3;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIN0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIN1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIN2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIN3    = 3'd4;

    // register reset values
    localparam logic [TOUT_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [PIN_W-1:0]  PIN0_RST    = 8'd11;
    localparam logic [PIN_W-1:0]  PIN1_RST    = 8'd12;
    localparam logic [PIN_W-1:0]  PIN2_RST    = 8'd24;
    localparam logic [PIN_W-1:0]  PIN3_RST    = 8'd25;

    typedef logic [NUM_PIN_REGS-1:0][PIN_W-1:0] t_pins;

    typedef enum logic {
        ALU_ADD,
        ALU_CMP
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              carry;
    } t_alu_rsp;

    typedef struct packed {
        logic                 hit;
        logic [BTN_IDX_W-1:0] idx;
    } t_lookup;

endpackage

`default_nettype wire

### rtl/core/button_long_press_detector.sv
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_mode, i_pin, i_now_ms
// result    out        o_out_valid / i_out_ready   o_pin_out, o_action, o_last
// config    in         i_cfg_wr_en (no wait)       i_cfg_idx, i_cfg_wdata
//
// press or release: accept, then one sequencer step with the adder.
// tick: accept, then one compare per button on the shared
// 33-bit adder, then one emit step per button.
// a stalled result holds only the step that wants to load the next one.
// reset is synchronous and active low; no clearing pass.
`default_nettype none

`include "button_long_press_detector_macros.svh"

module button_long_press_detector
    import blpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [1:0]            i_mode,
    input  wire [PIN_W-1:0]      i_pin,
    input  wire [TIME_W-1:0]     i_now_ms,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [PIN_W-1:0]     o_pin_out,
    output logic [1:0]           o_action,
    output logic                 o_last,
    input  wire                  i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [TOUT_W-1:0] w_timeout;
    t_pins             w_pins;
    t_lookup           w_lookup;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    // config registers and pin lookup
    blpd_cfg #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pin       (i_pin),
        .o_timeout   (w_timeout),
        .o_pins      (w_pins),
        .o_lookup    (w_lookup)
    );

    // shared add / compare unit
    blpd_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // sequencer
    blpd_seq #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_pin       (i_pin),
        .i_now_ms    (i_now_ms),
        .i_timeout   (w_timeout),
        .i_pins      (w_pins),
        .i_lookup    (w_lookup),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pin_out   (o_pin_out),
        .o_action    (o_action),
        .o_last      (o_last)
    );

    // only a tick gives more than one result
    `BLPD_ASSERT_NOW(a_single_last, o_out_valid && o_action != ACT_LONG, o_last, "single result without last")
    // a tick request keeps the sequencer busy
    `BLPD_ASSERT_NEXT(a_tick_busy, i_in_valid && o_in_ready && i_mode == MODE_TICK, !o_in_ready, "tick request did not start a walk")
    // an unused mode is dropped at once
    `BLPD_ASSERT_NEXT(a_none_idle, i_in_valid && o_in_ready && i_mode == MODE_NONE, o_in_ready, "unused mode left the sequencer busy")

endmodule

`default_nettype wire

### rtl/core/blpd_alu.sv
`default_nettype none

module blpd_alu
    import blpd_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [TIME_W-1:0] w_b;
    logic              w_cin;
    logic [TIME_W:0]   w_full;

    // one 33-bit adder: a + b for deadlines, a - b for the due compare
    always_comb begin
        w_b    = (i_req.op == ALU_CMP) ? ~i_req.b : i_req.b;
        w_cin  = (i_req.op == ALU_CMP);
        w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{TIME_W{1'b0}}, w_cin};
        o_rsp.sum   = w_full[TIME_W-1:0];
        o_rsp.carry = w_full[TIME_W];
    end

endmodule

`default_nettype wire

### rtl/core/blpd_cfg.sv
`default_nettype none

module blpd_cfg
    import blpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire [PIN_W-1:0]       i_pin,
    output logic [TOUT_W-1:0]     o_timeout,
    output t_pins                 o_pins,
    output t_lookup               o_lookup
);

    logic [TOUT_W-1:0] r_timeout;
    t_pins             r_pins;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_pins[0] <= PIN0_RST;
            r_pins[1] <= PIN1_RST;
            r_pins[2] <= PIN2_RST;
            r_pins[3] <= PIN3_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_TIMEOUT: r_timeout <= i_cfg_wdata;
                REG_PIN0:    r_pins[0] <= i_cfg_wdata[PIN_W-1:0];
                REG_PIN1:    r_pins[1] <= i_cfg_wdata[PIN_W-1:0];
                REG_PIN2:    r_pins[2] <= i_cfg_wdata[PIN_W-1:0];
                REG_PIN3:    r_pins[3] <= i_cfg_wdata[PIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pin to button, lowest button wins
    always_comb begin
        o_lookup.hit = 1'b0;
        o_lookup.idx = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
            if (r_pins[b] == i_pin) begin
                o_lookup.hit = 1'b1;
                o_lookup.idx = BTN_IDX_W'(b);
            end
        end
    end

    assign o_timeout = r_timeout;
    assign o_pins    = r_pins;

endmodule

`default_nettype wire

### rtl/core/blpd_seq.sv
`default_nettype none

module blpd_seq
    import blpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire [1:0]          i_mode,
    input  wire [PIN_W-1:0]    i_pin,
    input  wire [TIME_W-1:0]   i_now_ms,
    input  wire [TOUT_W-1:0]   i_timeout,
    input  wire t_pins         i_pins,
    input  wire t_lookup       i_lookup,
    output t_alu_req           o_alu_req,
    input  wire t_alu_rsp      i_alu_rsp,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [PIN_W-1:0]   o_pin_out,
    output logic [1:0]         o_action,
    output logic               o_last
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_EVENT
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_mode;
    logic [PIN_W-1:0]       r_pin;
    logic [TIME_W-1:0]      r_now;
    logic [IDX_W-1:0]       r_btn;
    logic [IDX_W-1:0]       r_idx;
    logic [NUM_BUTTONS-1:0] r_due;
    logic [TIME_W-1:0]      r_deadline [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_armed;
    logic [NUM_BUTTONS-1:0] r_long;
    logic                   r_out_valid;
    logic [PIN_W-1:0]       r_pin_out;
    logic [1:0]             r_action;
    logic                   r_last;

    logic                   w_slot_free;
    logic [NUM_BUTTONS-1:0] w_above;
    logic                   w_load;

    // shared adder: due compare while scanning, deadline sum otherwise
    always_comb begin
        o_alu_req.a  = r_now;
        if (r_state == S_SCAN) begin
            o_alu_req.op = ALU_CMP;
            o_alu_req.b  = r_deadline[r_idx];
        end else begin
            o_alu_req.op = ALU_ADD;
            o_alu_req.b  = {{(TIME_W - TOUT_W){1'b0}}, i_timeout};
        end
    end

    // output slot free when empty or being drained
    assign w_slot_free = !r_out_valid || i_out_ready;

    // due buttons still ahead of the walk
    assign w_above = (r_due >> r_idx) >> 1;

    // a result enters the output register this cycle
    always_comb begin
        case (r_state)
            S_EMIT: begin
                w_load = w_slot_free && r_due[r_idx];
            end
            S_EVENT: begin
                w_load = w_slot_free && ((r_mode == MODE_PRESS)
                         || (r_mode == MODE_RELEASE && (r_long[r_btn] || r_armed[r_btn])));
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // sequencer, button state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_armed     <= '0;
            r_long      <= '0;
        end else begin
            // load wins over drain
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode <= i_mode;
                        r_pin  <= i_pin;
                        r_now  <= i_now_ms;
                        r_btn  <= IDX_W'(i_lookup.idx);
                        r_idx  <= '0;
                        r_due  <= '0;
                        if ((i_mode == MODE_PRESS || i_mode == MODE_RELEASE)
                                && i_lookup.hit) begin
                            r_state <= S_EVENT;
                        end else if (i_mode == MODE_TICK) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // carry set means now >= deadline
                    r_due[r_idx] <= r_armed[r_idx] & i_alu_rsp.carry;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_due[r_idx] || w_slot_free) begin
                        if (r_due[r_idx]) begin
                            r_pin_out      <= i_pins[BTN_IDX_W'(r_idx)];
                            r_action       <= ACT_LONG;
                            r_last         <= (w_above == '0);
                            r_armed[r_idx] <= 1'b0;
                            r_long[r_idx]  <= 1'b1;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_EVENT: begin
                    case (r_mode)
                        MODE_PRESS: begin
                            if (w_slot_free) begin
                                r_deadline[r_btn] <= i_alu_rsp.sum;
                                r_armed[r_btn]    <= 1'b1;
                                r_pin_out         <= r_pin;
                                r_action          <= ACT_PRESS;
                                r_last            <= 1'b1;
                                r_state           <= S_IDLE;
                            end
                        end
                        MODE_RELEASE: begin
                            if (r_long[r_btn]) begin
                                if (w_slot_free) begin
                                    r_long[r_btn] <= 1'b0;
                                    r_pin_out     <= r_pin;
                                    r_action      <= ACT_LONG_RELEASE;
                                    r_last        <= 1'b1;
                                    r_state       <= S_IDLE;
                                end
                            end else if (r_armed[r_btn]) begin
                                if (w_slot_free) begin
                                    r_armed[r_btn] <= 1'b0;
                                    r_pin_out      <= r_pin;
                                    r_action       <= ACT_RELEASE;
                                    r_last         <= 1'b1;
                                    r_state        <= S_IDLE;
                                end
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pin_out   = r_pin_out;
    assign o_action    = r_action;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### bench/tb_button_long_press_detector.sv
`timescale 1ns / 1ps

module tb_button_long_press_detector;
    import blpd_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 10;
    localparam int NUM_BUTTONS     = 4;
    // a tick walks every button twice after the accept cycle, plus margin
    localparam int SETTLE_CYCLES   = 2 * NUM_BUTTONS + 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_REQUESTS  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

    typedef struct {
        logic [PIN_W-1:0] pin;
        logic [1:0]       action;
        logic             last;
    } t_btn_event;

    // tracks per-button timers and the button events each request should cause
    class button_event_scoreboard;
        logic [TOUT_W-1:0] timeout_ms;
        logic [PIN_W-1:0]  pins [NUM_PIN_REGS];
        logic [TIME_W-1:0] deadline_ms [NUM_PIN_REGS];
        bit                armed [NUM_PIN_REGS];
        bit                held_long [NUM_PIN_REGS];
        t_btn_event        events_due [$];
        int                errors;

        function new();
            timeout_ms = TIMEOUT_RST;
            pins[0] = PIN0_RST;
            pins[1] = PIN1_RST;
            pins[2] = PIN2_RST;
            pins[3] = PIN3_RST;
            for (int b = 0; b < NUM_PIN_REGS; b++) begin
                deadline_ms[b] = '0;
                armed[b] = 1'b0;
                held_long[b] = 1'b0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TIMEOUT: timeout_ms = data[TOUT_W-1:0];
                REG_PIN0:    pins[0] = data[PIN_W-1:0];
                REG_PIN1:    pins[1] = data[PIN_W-1:0];
                REG_PIN2:    pins[2] = data[PIN_W-1:0];
                REG_PIN3:    pins[3] = data[PIN_W-1:0];
                default: ;
            endcase
        endfunction

        // lowest numbered button wins when pins are duplicated
        function int button_of(logic [PIN_W-1:0] pin);
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (pins[b] == pin) return b;
            end
            return -1;
        endfunction

        function void add_event(logic [PIN_W-1:0] pin, logic [1:0] action);
            t_btn_event ev;
            ev.pin = pin;
            ev.action = action;
            ev.last = 1'b0;
            events_due.push_back(ev);
        endfunction

        function void note_request(logic [1:0] mode, logic [PIN_W-1:0] pin,
                                   logic [TIME_W-1:0] now);
            int b;
            int first;
            first = events_due.size();
            b = button_of(pin);
            if (mode == MODE_PRESS && b >= 0) begin
                // long flag survives a new press
                deadline_ms[b] = now + timeout_ms;
                armed[b] = 1'b1;
                add_event(pin, ACT_PRESS);
            end else if (mode == MODE_RELEASE && b >= 0) begin
                if (held_long[b]) begin
                    held_long[b] = 1'b0;
                    add_event(pin, ACT_LONG_RELEASE);
                end else if (armed[b]) begin
                    armed[b] = 1'b0;
                    deadline_ms[b] = '0;
                    add_event(pin, ACT_RELEASE);
                end
            end else if (mode == MODE_TICK) begin
                for (int k = 0; k < NUM_BUTTONS; k++) begin
                    if (armed[k] && deadline_ms[k] <= now) begin
                        armed[k] = 1'b0;
                        deadline_ms[k] = '0;
                        held_long[k] = 1'b1;
                        add_event(pins[k], ACT_LONG);
                    end
                end
            end
            if (events_due.size() > first) events_due[events_due.size() - 1].last = 1'b1;
        endfunction

        function void check_event(logic [PIN_W-1:0] pin, logic [1:0] action, logic last);
            t_btn_event ev;
            if (events_due.size() == 0) begin
                $display("%0t: unexpected event pin %0d action %0d last %0d",
                         $time, pin, action, last);
                errors++;
                return;
            end
            ev = events_due.pop_front();
            if (ev.pin !== pin || ev.action !== action || ev.last !== last) begin
                $display({"%0t: event mismatch expected pin %0d action %0d last %0d, ",
                          "got pin %0d action %0d last %0d"},
                         $time, ev.pin, ev.action, ev.last, pin, action, last);
                errors++;
            end
        endfunction

        function int pending();
            return events_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_mode;
    logic [PIN_W-1:0]      i_pin;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIN_W-1:0]      o_pin_out;
    logic [1:0]            o_action;
    logic                  o_last;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    button_event_scoreboard sb;
    int                     burst_left;
    bit                     steady_send;
    int                     hold_off_cycles;
    int                     idle_cycles;
    logic [TIME_W-1:0]      clock_ms;

    button_long_press_detector #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_pin       (i_pin),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pin_out   (o_pin_out),
        .o_action    (o_action),
        .o_last      (o_last),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_event(o_pin_out, o_action, o_last);
            if (i_in_valid && o_in_ready) sb.note_request(i_mode, i_pin, i_now_ms);
        end
    end

    // watchdog on cycles without any accepted request or event
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("button_long_press_detector test failed");
        $finish;
    end

    // event sink with changing stall patterns and an on-demand long hold-off
    initial begin
        int hold_left;
        int pattern_left;
        int pattern;
        i_out_ready = 1'b0;
        hold_left = 0;
        pattern_left = 0;
        pattern = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_left = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (pattern_left == 0) begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                case (pattern)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = ($urandom_range(0, 1) == 0);
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = (pattern_left % 3 != 0);
                endcase
            end
        end
    end

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // sender works in bursts with random gaps unless steady
    task automatic offer_request(input logic [1:0] mode, input logic [PIN_W-1:0] pin,
                                 input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = steady_send ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_mode = mode;
        i_pin = pin;
        i_now_ms = now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and let every due event come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_phase(input int kind);
        logic [TOUT_W-1:0] tout;
        logic [PIN_W-1:0]  pin;
        case (kind)
            0: tout = '0;
            1: tout = '1;
            2: tout = TOUT_W'($urandom_range(1, 200));
            default: tout = TOUT_W'($urandom_range(0, 65535));
        endcase
        write_config(REG_TIMEOUT, tout);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            // duplicated pins in the duplicate kind
            if (kind == 3 && b >= 2) pin = sb.pins[b - 2];
            else pin = PIN_W'($urandom_range(0, 255));
            write_config(CFG_IDX_W'(REG_PIN0 + b), {8'($urandom_range(0, 255)), pin});
        end
        write_config(CFG_IDX_W'($urandom_range(REG_PIN3 + 1, REG_LAST_INDEX)),
                     16'($urandom()));
        if (kind == 1) clock_ms = 32'hFFFF_0000 | $urandom_range(0, 65535);
        else clock_ms = $urandom_range(0, 1000000);
    endtask

    // mostly well-formed traffic on mapped pins with a steadily rising clock
    task automatic run_random(input int n);
        int                counted;
        int                r;
        logic [1:0]        mode;
        logic [PIN_W-1:0]  pin;
        logic [TIME_W-1:0] now;
        counted = 0;
        while (counted < n) begin
            r = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, sb.timeout_ms / 3 + 3);
            now = clock_ms;
            if ($urandom_range(0, 9) == 0) pin = PIN_W'($urandom_range(0, 255));
            else pin = sb.pins[$urandom_range(0, NUM_BUTTONS - 1)];
            if (r < 8) begin
                mode = 2'($urandom_range(0, 3));
                pin = PIN_W'($urandom_range(0, 255));
                now = $urandom();
            end else if (r < 45) begin
                mode = MODE_PRESS;
            end else if (r < 75) begin
                mode = MODE_RELEASE;
            end else begin
                mode = MODE_TICK;
            end
            if (mode == MODE_TICK || (mode != MODE_NONE && sb.button_of(pin) >= 0))
                counted++;
            offer_request(mode, pin, now);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_PRESS;
        i_pin = '0;
        i_now_ms = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = REG_TIMEOUT;
        i_cfg_wdata = '0;
        burst_left = 0;
        steady_send = 1'b0;
        hold_off_cycles = 0;
        clock_ms = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset mapping: press, deadline edge, press while long, releases
        offer_request(MODE_PRESS, PIN0_RST, 32'd0);
        offer_request(MODE_TICK, 8'd0, 32'd999);
        offer_request(MODE_TICK, 8'd255, 32'd1000);
        offer_request(MODE_PRESS, PIN0_RST, 32'd1500);
        offer_request(MODE_RELEASE, PIN0_RST, 32'd1600);
        offer_request(MODE_TICK, 8'd0, 32'd2500);
        offer_request(MODE_RELEASE, PIN0_RST, 32'd2600);
        offer_request(MODE_RELEASE, PIN0_RST, 32'd2700);
        offer_request(MODE_PRESS, PIN1_RST, 32'd3000);
        offer_request(MODE_RELEASE, PIN1_RST, 32'd3100);
        // unmatched pin and unused mode
        offer_request(MODE_PRESS, 8'd99, 32'd3200);
        offer_request(MODE_RELEASE, 8'd99, 32'd3300);
        offer_request(MODE_NONE, PIN0_RST, 32'd3400);
        // deadlines wrapping past the top of the clock, all four due at once
        offer_request(MODE_PRESS, PIN0_RST, 32'hFFFF_FF00);
        offer_request(MODE_PRESS, PIN1_RST, 32'hFFFF_FF00);
        offer_request(MODE_PRESS, PIN2_RST, 32'hFFFF_FF00);
        offer_request(MODE_PRESS, PIN3_RST, 32'hFFFF_FF00);
        offer_request(MODE_TICK, 8'd0, 32'hFFFF_FFFF);
        offer_request(MODE_RELEASE, PIN3_RST, 32'hFFFF_FFFF);
        wait_idle();

        // zero timeout, extreme and duplicated pins, unused register index
        write_config(REG_TIMEOUT, 16'd0);
        write_config(REG_PIN0, 16'hA500);
        write_config(REG_PIN1, 16'h00FF);
        write_config(REG_PIN2, 16'hFF00);
        write_config(REG_PIN3, 16'h5AFF);
        write_config(CFG_IDX_W'(REG_PIN3 + 1), 16'hFFFF);
        offer_request(MODE_PRESS, 8'd0, 32'hFFFF_FFFF);
        offer_request(MODE_TICK, 8'd0, 32'hFFFF_FFFF);
        offer_request(MODE_PRESS, 8'd255, 32'd5);
        offer_request(MODE_RELEASE, 8'd255, 32'd5);
        offer_request(MODE_RELEASE, 8'd0, 32'd6);

        // random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p == 2) hold_off_cycles = HOLD_OFF_CYCLES;
            configure_phase(p);
            if (p == 2) begin
                // fill the block while the sink holds off
                steady_send = 1'b1;
                for (int k = 0; k < 12; k++)
                    offer_request(MODE_PRESS, sb.pins[k % NUM_BUTTONS], clock_ms);
            end
            steady_send = (p == 2 || p == 3);
            run_random(PHASE_REQUESTS);
            steady_send = 1'b0;
        end
        wait_idle();

        if (sb.errors == 0)
            $display("button_long_press_detector test passed");
        else
            $display("button_long_press_detector test failed");
        $finish;
    end

endmodule
